@@ rtl/bmh_pkg.sv @@
// types and constants shared by the heap queue modules
`default_nettype none
package bmh_pkg;

  localparam int KEY_W   = 32;
  localparam int ROW_W   = 16;
  localparam int COL_W   = 16;
  localparam int KIND_W  = 8;
  localparam int OCC_W   = 11;
  localparam int ENTRY_W = KEY_W + ROW_W + COL_W + KIND_W;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 88;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef enum logic {
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef struct packed {
    logic move;
    logic pick_b;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_GET,
    ST_DN_RD,
    ST_DN_CMP,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/bmh_ram.sv @@
// generic ram, one write port and two registered read ports
`default_nettype none
module bmh_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ rtl/bmh_cmp.sv @@
// shared key compare and child select unit for both sift directions
`default_nettype none
module bmh_cmp
  import bmh_pkg::*;
(
  input  wire dir_t   dir,
  input  wire entry_t hole,
  input  wire entry_t cand_a,
  input  wire entry_t cand_b,
  input  wire logic   b_ok,
  output step_t       step,
  output entry_t      chosen
);

  logic a_lt_b;

  always_comb begin
    a_lt_b = $signed(cand_a.key) < $signed(cand_b.key);
    step   = '0;
    chosen = cand_a;
    unique case (dir)
      DIR_UP: begin
        // parent drops when it is not above the rising entry
        step.move = $signed(cand_a.key) <= $signed(hole.key);
      end
      DIR_DOWN: begin
        // right child only when strictly larger
        step.pick_b = b_ok && a_lt_b;
        chosen      = step.pick_b ? cand_b : cand_a;
        step.move   = $signed(hole.key) < $signed(chosen.key);
      end
      default: begin
        step = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/binary_max_heap_priority_queue_top.sv @@
// top level of the binary max-heap priority queue with its sift sequencer
//
// channel  dir  signals                         contents
// s        in   s_tvalid s_tready s_tdata s_tuser  one request: insert or remove
// m        out  m_tvalid m_tready m_tdata          status, count and root entry
//
// an insert climbs one level at a time until it reaches the root or a compare stops
// it; a remove first fetches the last entry, then descends one level at a time until
// it ends at a leaf or a compare stops it; a refused request goes straight to the
// result, and the default capacity is 1024 entries
// each level is one registered read of the entry ram then one compare/write
// the request port is ready only in idle; a finished result waits in its
// output register while the next request is taken
// rst clears the sequencer, the count and the output valid; the ram needs no
// clearing since only slots below the count are ever read
`default_nettype none
module binary_max_heap_priority_queue_top
  import bmh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // priority_req[31:0], entry_row[47:32], entry_column[63:48], entry_kind[71:64]
  input  wire logic [IN_W-1:0]  s_tdata,
  // action[0]
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // accepted[0], occupancy[11:1], is_empty[12], top_priority[44:13],
  // top_row[60:45], top_column[76:61], top_kind[84:77], zero pad[87:85]
  output logic      [OUT_W-1:0] m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  entry_t        hole;
  entry_t        top;
  logic          ok;

  // output register
  logic             out_ok;
  logic [OCC_W-1:0] out_occ;
  logic             out_empty;
  entry_t           out_top;

  // ram side
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [ENTRY_W-1:0] ram_rdata_a;
  logic [ENTRY_W-1:0] ram_rdata_b;
  entry_t        rd_a;
  entry_t        rd_b;

  // compare unit
  dir_t   cmp_dir;
  step_t  step;
  entry_t chosen;

  // index arithmetic
  logic [AW-1:0] parent;
  logic [XW-1:0] child_x;
  logic [XW-1:0] child_r_x;
  logic          child_none;
  logic          right_ok;
  logic          accept;
  logic          is_full;
  logic          is_zero;
  logic          out_free;
  entry_t        in_entry;

  assign rd_a = entry_t'(ram_rdata_a);
  assign rd_b = entry_t'(ram_rdata_b);

  assign parent     = (pos - AW'(1)) >> 1;
  assign child_x    = (XW'(pos) << 1) | XW'(1);
  assign child_r_x  = child_x + XW'(1);
  assign child_none = child_x >= XW'(count);
  assign right_ok   = child_r_x < XW'(count);

  assign accept   = s_tvalid && s_tready;
  assign is_full  = count >= CW'(CAPACITY);
  assign is_zero  = count == '0;
  assign out_free = !m_tvalid || m_tready;

  assign in_entry.key  = s_tdata[31:0];
  assign in_entry.row  = s_tdata[47:32];
  assign in_entry.col  = s_tdata[63:48];
  assign in_entry.kind = s_tdata[71:64];

  assign cmp_dir = (state == ST_UP_CMP) ? DIR_UP : DIR_DOWN;

  bmh_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .rdata_a(ram_rdata_a),
    .raddr_b(ram_raddr_b),
    .rdata_b(ram_rdata_b)
  );

  bmh_cmp u_cmp (
    .dir   (cmp_dir),
    .hole  (hole),
    .cand_a(rd_a),
    .cand_b(rd_b),
    .b_ok  (right_ok),
    .step  (step),
    .chosen(chosen)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == ACT_INSERT) begin
            state_next = is_full ? ST_RESULT : ST_UP_RD;
          end else begin
            state_next = is_zero ? ST_RESULT : ST_DN_LAST;
          end
        end
      end
      ST_UP_RD:   state_next = (pos == '0) ? ST_RESULT : ST_UP_CMP;
      ST_UP_CMP:  state_next = step.move ? ST_UP_RD : ST_RESULT;
      ST_DN_LAST: state_next = ST_DN_GET;
      ST_DN_GET:  state_next = is_zero ? ST_RESULT : ST_DN_RD;
      ST_DN_RD:   state_next = child_none ? ST_RESULT : ST_DN_CMP;
      ST_DN_CMP:  state_next = step.move ? ST_DN_RD : ST_RESULT;
      ST_RESULT:  state_next = out_free ? ST_IDLE : ST_RESULT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ram control and handshake
  always_comb begin
    s_tready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = hole;
    ram_raddr_a = parent;
    ram_raddr_b = child_r_x[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_UP_RD: begin
        // at the root the rising entry settles, otherwise fetch its parent
        ram_we      = (pos == '0);
        ram_raddr_a = parent;
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = step.move ? rd_a : hole;
      end
      ST_DN_LAST: begin
        // count already decremented, so it indexes the last entry
        ram_raddr_a = AW'(count);
      end
      ST_DN_GET: begin
        ram_we = 1'b0;
      end
      ST_DN_RD: begin
        ram_we      = child_none;
        ram_raddr_a = child_x[AW-1:0];
        ram_raddr_b = child_r_x[AW-1:0];
      end
      ST_DN_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = step.move ? chosen : hole;
      end
      ST_RESULT: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (s_tuser == ACT_INSERT && !is_full) begin
          count <= count + CW'(1);
        end else if (s_tuser == ACT_REMOVE && !is_zero) begin
          count <= count - CW'(1);
        end
      end
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hole <= in_entry;
      pos  <= AW'(count);
      ok   <= (s_tuser == ACT_INSERT) ? !is_full : !is_zero;
    end
    if (state == ST_UP_CMP && step.move) begin
      pos <= parent;
    end
    if (state == ST_DN_GET) begin
      hole <= rd_a;
      pos  <= '0;
    end
    if (state == ST_DN_CMP && step.move) begin
      pos <= step.pick_b ? child_r_x[AW-1:0] : child_x[AW-1:0];
    end
    // root copy follows every write to slot zero
    if (ram_we && ram_waddr == '0) begin
      top <= ram_wdata;
    end
    if (state == ST_RESULT && out_free) begin
      out_ok    <= ok;
      out_occ   <= OCC_W'(count);
      out_empty <= is_zero;
      out_top   <= is_zero ? '0 : top;
    end
  end

  assign m_tdata = {3'b000, out_top.kind, out_top.col, out_top.row, out_top.key,
                    out_empty, out_occ, out_ok};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !accept) |=> $stable(count))
    else $error("count moved without a request");

  a_down_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_RD) |-> (CW'(pos) < count))
    else $error("sift down position outside heap");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RESULT))
    else $error("result raised outside result state");

endmodule
`default_nettype wire

@@ bench/binary_max_heap_checker.sv @@
// checker for the heap queue: watches both channels, predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none
module bmh_queue_checker
  import bmh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tuser,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,
  output int                    fail_count,
  output int                    due_count,
  output int                    model_count,
  output int                    checked_count,
  output int                    full_refusals,
  output int                    empty_refusals
);

  typedef struct packed {
    logic             ok;
    logic [OCC_W-1:0] occ;
    logic             empty;
    entry_t           top;
  } heap_status_t;

  entry_t       slots [CAPACITY];
  int unsigned  held = 0;
  heap_status_t due_status [$];
  int           err_n = 0;
  int           checked_n = 0;
  int           full_n = 0;
  int           empty_n = 0;

  // insert sifts up past an equal parent; remove sifts down, left child on a tie
  function automatic heap_status_t heap_apply(input logic act, input entry_t item);
    heap_status_t r;
    entry_t       tmp;
    int unsigned  c;
    int unsigned  p;
    bit           done;
    r = '0;
    done = 1'b0;
    if (act == ACT_INSERT) begin
      if (held < CAPACITY) begin
        slots[held] = item;
        c = held;
        while (c > 0 && !done) begin
          p = (c - 1) / 2;
          if ($signed(slots[p].key) <= $signed(slots[c].key)) begin
            tmp = slots[p];
            slots[p] = slots[c];
            slots[c] = tmp;
            c = p;
          end else begin
            done = 1'b1;
          end
        end
        held++;
        r.ok = 1'b1;
      end
    end else if (held > 0) begin
      held--;
      slots[0] = slots[held];
      p = 0;
      c = 1;
      while (c < held && !done) begin
        if (c + 1 < held && $signed(slots[c].key) < $signed(slots[c + 1].key)) c++;
        if ($signed(slots[p].key) < $signed(slots[c].key)) begin
          tmp = slots[p];
          slots[p] = slots[c];
          slots[c] = tmp;
          p = c;
          c = 2 * p + 1;
        end else begin
          done = 1'b1;
        end
      end
      r.ok = 1'b1;
    end
    r.occ = held[OCC_W-1:0];
    r.empty = (held == 0);
    if (held != 0) r.top = slots[0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_n++;
    end
  endtask

  always @(posedge clk) begin
    heap_status_t want;
    entry_t       item;
    if (!rst) begin
      // results first: a result leaving at this edge belongs to an older request
      if (m_tvalid && m_tready) begin
        if (due_status.size() == 0) begin
          $error("result with no request outstanding");
          err_n++;
        end else begin
          want = due_status.pop_front();
          check_field("accepted", want.ok, m_tdata[0]);
          check_field("occupancy", want.occ, m_tdata[11:1]);
          check_field("is_empty", want.empty, m_tdata[12]);
          check_field("top_priority", $signed(want.top.key), $signed(m_tdata[44:13]));
          check_field("top_row", want.top.row, m_tdata[60:45]);
          check_field("top_column", want.top.col, m_tdata[76:61]);
          check_field("top_kind", want.top.kind, m_tdata[84:77]);
          checked_n++;
        end
      end
      if (s_tvalid && s_tready) begin
        item.key  = s_tdata[31:0];
        item.row  = s_tdata[47:32];
        item.col  = s_tdata[63:48];
        item.kind = s_tdata[71:64];
        want = heap_apply(s_tuser, item);
        if (!want.ok && s_tuser == ACT_INSERT) full_n++;
        if (!want.ok && s_tuser == ACT_REMOVE) empty_n++;
        due_status.push_back(want);
      end
    end
    fail_count     <= err_n;
    due_count      <= due_status.size();
    model_count    <= held;
    checked_count  <= checked_n;
    full_refusals  <= full_n;
    empty_refusals <= empty_n;
  end

endmodule
`default_nettype wire

@@ bench/tb_binary_max_heap_priority_queue_top.sv @@
// stimulus and verdict for the binary max-heap priority queue
`timescale 1ns / 1ps
`default_nettype none
module tb_binary_max_heap_priority_queue_top;
  import bmh_pkg::*;

  localparam int CAPACITY = 1024;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // priority_req[31:0], entry_row[47:32], entry_column[63:48], entry_kind[71:64]
  logic [IN_W-1:0]  s_tdata = '0;
  // action[0]
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // accepted[0], occupancy[11:1], is_empty[12], top_priority[44:13],
  // top_row[60:45], top_column[76:61], top_kind[84:77], zero pad[87:85]
  logic [OUT_W-1:0] m_tdata;

  // no idling on either side once set
  logic calm = 1'b0;

  int fail_count;
  int due_count;
  int model_count;
  int checked_count;
  int full_refusals;
  int empty_refusals;
  int inserts_sent = 0;
  int removes_sent = 0;

  binary_max_heap_priority_queue_top #(.CAPACITY(CAPACITY)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bmh_queue_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .due_count      (due_count),
    .model_count    (model_count),
    .checked_count  (checked_count),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  always #4 clk = ~clk;

  // hand one request to the block and hold it until taken, then maybe go idle
  task automatic offer(input logic act, input logic [31:0] key, input logic [15:0] row,
                       input logic [15:0] col, input logic [7:0] kind);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {kind, col, row, key};
    do @(posedge clk); while (!s_tready);
    if (act == ACT_INSERT) inserts_sent++;
    else removes_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // priorities lean on the extremes and on a narrow band so that ties are common
  function automatic logic [31:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      1, 2: begin
        return 32'($signed($urandom_range(0, 16)) - 8);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic random_request(input int insert_pct);
    logic act;
    act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    offer(act, pick_priority(), 16'($urandom_range(0, 65535)),
          16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  // receiver: short random stalls, plus one long hold-off so the block backs up
  initial begin : sink
    int idle_left;
    int taken;
    bit held_off;
    idle_left = 0;
    taken = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) taken++;
      if (idle_left > 0) begin
        idle_left--;
        if (idle_left == 0) m_tready <= 1'b1;
      end else if (!held_off && taken >= 400) begin
        held_off = 1'b1;
        idle_left = 600;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(1, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // remove from an empty heap is refused
    offer(ACT_REMOVE, 32'h0, 16'h0, 16'h0, 8'h0);
    // extremes of every field
    offer(ACT_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    offer(ACT_INSERT, 32'h8000_0000, 16'h0000, 16'h0000, 8'h00);
    // equal priority rises past the root
    offer(ACT_INSERT, 32'h7FFF_FFFF, 16'h1234, 16'h5678, 8'h5A);
    offer(ACT_INSERT, 32'h0000_0000, 16'hA5A5, 16'h5A5A, 8'hA5);
    offer(ACT_INSERT, 32'hFFFF_FFFF, 16'h0001, 16'h8000, 8'h80);
    // drain to empty, the last two removes refused
    repeat (7) offer(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    // equal children: the left one is chosen
    offer(ACT_INSERT, 32'd10, 16'd1, 16'd1, 8'd1);
    offer(ACT_INSERT, 32'd3, 16'd2, 16'd2, 8'd2);
    offer(ACT_INSERT, 32'd3, 16'd3, 16'd3, 8'd3);
    offer(ACT_INSERT, 32'd1, 16'd4, 16'd4, 8'd4);
    repeat (5) offer(ACT_REMOVE, 32'h0, 16'h0, 16'h0, 8'h0);

    // balanced mix around a small heap
    repeat (300) random_request(60);
    // fill to capacity, then keep pushing so inserts are refused
    while (model_count < CAPACITY) random_request(97);
    repeat (20) random_request(95);
    // drain a good part of the heap
    repeat (330) random_request(10);
    // final stretch with no idling
    calm <= 1'b1;
    repeat (150) random_request(50);
    s_tvalid <= 1'b0;

    while (due_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d inserts and %0d removes sent, %0d results checked",
             inserts_sent, removes_sent, checked_count);
    $display("%0d inserts refused on a full heap, %0d removes refused on an empty heap",
             full_refusals, empty_refusals);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d results outstanding", due_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
